/* design/assert_macros.svh */
// Assertion macros shared by the execution unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tsap_pkg.sv */
// Package: types, codes and sizes of the two-stage execution unit.
`default_nettype none
package tsap_pkg;
    localparam int LANES = 4;
    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W = $clog2(LANES + 1);

    localparam logic [1:0] REQ_PUSH    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_FLUSH   = 2'd2;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MULU = 3'd2;
    localparam logic [2:0] OP_DIVU = 3'd3;
    localparam logic [2:0] OP_REMU = 3'd4;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  opcode;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [5:0]  dest_reg;
        logic [31:0] instr_pc;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic        push_accepted;
        logic [5:0]  result_dest;
        logic [63:0] result_value;
        logic        divide_fault;
        logic [31:0] result_pc;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] op_a;
        logic [63:0] op_b;
        logic [5:0]  dest;
        logic [31:0] pc;
    } t_slot;

    typedef struct packed {
        logic push;
        logic flush;
        logic move;
        logic load_ack;
        logic load_res;
        logic start;
        logic idx_clr;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic s2_empty;
        logic slot_last;
        logic exec_busy;
    } t_sts;
endpackage
`default_nettype wire

/* design/tsap_exec.sv */
// Multi-cycle 64-bit ALU: add, sub, shared 32x32 multiplier, radix-2 divider.
`default_nettype none
`include "assert_macros.svh"
module tsap_exec (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [2:0]  i_op,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_busy,
    output logic [63:0]      o_value,
    output logic             o_fault
);
    import tsap_pkg::*;

    logic        r_busy;
    logic [2:0]  r_op;
    logic [63:0] r_a, r_b, r_q, r_rem, r_val;
    logic [5:0]  r_cnt;
    logic        r_fault;

    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [64:0] rem_sh, diff;
    logic        take;
    logic [63:0] rem_nx, q_nx;

    always_comb begin
        mul_x  = (r_cnt == 6'd2) ? r_a[63:32] : r_a[31:0];
        mul_y  = (r_cnt == 6'd1) ? r_b[63:32] : r_b[31:0];
        mul_p  = 64'(mul_x) * 64'(mul_y);
        rem_sh = {r_rem, r_q[63]};
        diff   = rem_sh - {1'b0, r_b};
        take   = !diff[64];
        rem_nx = take ? diff[63:0] : rem_sh[63:0];
        q_nx   = {r_q[62:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_op    <= i_op;
            r_a     <= i_a;
            r_b     <= i_b;
            r_q     <= i_a;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_val   <= '0;
            r_fault <= 1'b0;
        end else if (r_busy) begin
            unique case (r_op)
                OP_ADD: begin
                    r_val  <= r_a + r_b;
                    r_busy <= 1'b0;
                end
                OP_SUB: begin
                    r_val  <= r_a - r_b;
                    r_busy <= 1'b0;
                end
                OP_MULU: begin
                    if (r_cnt == 6'd0) begin
                        r_val <= mul_p;
                    end else begin
                        r_val <= r_val + {mul_p[31:0], 32'd0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd2) begin
                        r_busy <= 1'b0;
                    end
                end
                OP_DIVU, OP_REMU: begin
                    if (r_b == 64'd0) begin
                        r_val   <= '0;
                        r_fault <= 1'b1;
                        r_busy  <= 1'b0;
                    end else begin
                        r_rem <= rem_nx;
                        r_q   <= q_nx;
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            r_val  <= (r_op == OP_DIVU) ? q_nx : rem_nx;
                            r_busy <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_val  <= '0;
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy  = r_busy;
    assign o_value = r_val;
    assign o_fault = r_fault;

    `ASSERT_IMPL(a_mul_steps, i_clk, i_rst_n, r_busy && r_op == OP_MULU, r_cnt <= 6'd2, "multiply ran past three steps")
endmodule
`default_nettype wire

/* design/tsap_datapath.sv */
// Datapath: stage slot storage, slot selection, result register.
`default_nettype none
`include "assert_macros.svh"
module tsap_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tsap_pkg::t_in_item i_item,
    input  wire tsap_pkg::t_cmd     i_cmd,
    output tsap_pkg::t_sts          o_sts,
    output tsap_pkg::t_out_item     o_out
);
    import tsap_pkg::*;

    t_slot            r_s1 [LANES];
    t_slot            r_s2 [LANES];
    logic [CNT_W-1:0] r_s1cnt, r_s2cnt;
    logic [IDX_W-1:0] r_idx;
    t_out_item        r_out;
    t_slot            cur;
    logic             s1_full;
    logic             exec_busy, exec_fault;
    logic [63:0]      exec_val;

    assign cur     = r_s2[r_idx];
    assign s1_full = (r_s1cnt == CNT_W'(LANES));

    tsap_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (cur.opcode),
        .i_a     (cur.op_a),
        .i_b     (cur.op_b),
        .o_busy  (exec_busy),
        .o_value (exec_val),
        .o_fault (exec_fault)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1cnt <= '0;
            r_s2cnt <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.flush) begin
                r_s1cnt <= '0;
                r_s2cnt <= '0;
            end else if (i_cmd.move) begin
                r_s2cnt <= r_s1cnt;
                r_s1cnt <= '0;
                for (int k = 0; k < LANES; k++) begin
                    r_s2[k] <= r_s1[k];
                end
            end else if (i_cmd.push && !s1_full) begin
                r_s1[r_s1cnt[IDX_W-1:0]] <= '{opcode: i_item.opcode, op_a: i_item.operand_a,
                                              op_b: i_item.operand_b, dest: i_item.dest_reg,
                                              pc: i_item.instr_pc};
                r_s1cnt <= r_s1cnt + CNT_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack) begin
            r_out <= '{result_kind: KIND_ACK, push_accepted: !s1_full, result_dest: '0,
                       result_value: '0, divide_fault: 1'b0, result_pc: '0,
                       last_result: 1'b1};
        end else if (i_cmd.load_res) begin
            r_out <= '{result_kind: KIND_RESULT, push_accepted: 1'b0, result_dest: cur.dest,
                       result_value: exec_val, divide_fault: exec_fault, result_pc: cur.pc,
                       last_result: o_sts.slot_last};
        end
    end

    assign o_sts = '{s2_empty:  (r_s2cnt == '0),
                     slot_last: ((CNT_W'(r_idx) + CNT_W'(1)) == r_s2cnt),
                     exec_busy: exec_busy};
    assign o_out = r_out;

    `ASSERT_ALWAYS(a_s1cnt_range, i_clk, i_rst_n, r_s1cnt <= CNT_W'(LANES), "stage one count overflow")
endmodule
`default_nettype wire

/* design/tsap_ctrl.sv */
// Controller: request decode, slot sequencing, output valid.
`default_nettype none
`include "assert_macros.svh"
module tsap_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic [1:0]     i_req,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire tsap_pkg::t_sts i_sts,
    output tsap_pkg::t_cmd      o_cmd
);
    import tsap_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_START, S_RUN} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free, in_fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == S_IDLE && out_free);
    assign in_fire    = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_req)
                        REQ_PUSH: begin
                            o_cmd.push     = 1'b1;
                            o_cmd.load_ack = 1'b1;
                        end
                        REQ_ADVANCE: begin
                            if (i_sts.s2_empty) begin
                                o_cmd.move = 1'b1;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = S_START;
                            end
                        end
                        REQ_FLUSH: o_cmd.flush = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (!i_sts.exec_busy && out_free) begin
                    o_cmd.load_res = 1'b1;
                    if (i_sts.slot_last) begin
                        o_cmd.move = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_START;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.load_ack || o_cmd.load_res) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_ack || o_cmd.load_res, !r_out_valid || !i_out_stall, "result register overwritten while held")
    `ASSERT_NEXT(a_start_run, i_clk, i_rst_n, r_state == S_START, r_state == S_RUN && i_sts.exec_busy, "execution did not start")
endmodule
`default_nettype wire

/* design/two_stage_alu_pipeline_core.sv */
// Top level of the two-stage integer execution unit.
// Push: acknowledgement registered on acceptance; flush empties both stages.
// Advance: if stage two is empty, moves stage one there; else runs its slots in turn
// (multiply: three 32x32 steps on one multiplier; divide/remainder: 64 radix-2 steps).
// One transaction is worked at a time; input is stalled until its results are loaded.
// Synchronous active-low reset empties both stages and clears the output valid.
`default_nettype none
module two_stage_alu_pipeline_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire tsap_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tsap_pkg::t_out_item      o_out_item
);
    import tsap_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tsap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req       (i_in_item.req_type),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tsap_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out_item)
    );
endmodule
`default_nettype wire
